// ===== rtl/nps_pkg.sv =====
// Shared types, constants and helpers for the nearest point search block.
// Depends on nothing; every other file in rtl refers to it by scoped names.
package nps_pkg;

  localparam int CoordBits = 16;
  localparam int IndexBits = 10;
  localparam int MaxPointsDefault = 1024;

  // Squared distance: each term fits 2*CoordBits, the sum of three needs two more.
  localparam int SqBits = 2 * CoordBits;
  localparam int DistBits = SqBits + 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [IndexBits-1:0] index_t;
  typedef logic [SqBits-1:0] sq_t;
  typedef logic [DistBits-1:0] dist_t;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic accept;
    logic rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic scan_last;
    logic pipe_busy;
  } status_t;

  function automatic logic [CoordBits-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [CoordBits:0] d;
    d = (CoordBits + 1)'(a) - (CoordBits + 1)'(b);
    return d[CoordBits] ? CoordBits'(-d) : CoordBits'(d);
  endfunction

endpackage

// ===== rtl/nps_in_if.sv =====
// Input channel of the nearest point search block: valid, ready and one item.
// Depends on nps_pkg for the coordinate type.
interface nps_in_if;
  logic valid;
  logic ready;
  logic [1:0] kind;
  nps_pkg::coord_t px;
  nps_pkg::coord_t py;
  nps_pkg::coord_t pz;

  modport source (output valid, output kind, output px, output py, output pz, input ready);
  modport sink (input valid, input kind, input px, input py, input pz, output ready);
endinterface

// ===== rtl/nps_out_if.sv =====
// Result channel of the nearest point search block: valid, ready and one word.
// Depends on nps_pkg for the coordinate and index types.
interface nps_out_if;
  logic valid;
  logic ready;
  logic found;
  nps_pkg::index_t best_index;
  nps_pkg::coord_t best_x;
  nps_pkg::coord_t best_y;
  nps_pkg::coord_t best_z;
  logic table_full;

  modport source (output valid, output found, output best_index, output best_x,
                  output best_y, output best_z, output table_full, input ready);
  modport sink (input valid, input found, input best_index, input best_x,
                input best_y, input best_z, input table_full, output ready);
endinterface

// ===== rtl/nps_ctrl.sv =====
// Controller for the nearest point search block: accepts words, sequences the
// scan and hands results to the output register. Depends on nps_pkg.
module nps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_kind,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  nps_pkg::status_t  status,
  output nps_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_ready = (state == ST_IDLE) && !rst;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.accept = 1'b1;
          if (nps_pkg::kind_t'(in_kind) == nps_pkg::KIND_QUERY && !status.empty) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          out_valid_next = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/nps_datapath.sv =====
// Datapath for the nearest point search block: point memory, fill count, the
// distance pipeline, the running best and the result register. Depends on nps_pkg.
module nps_datapath #(
  parameter int MAX_POINTS = nps_pkg::MaxPointsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  nps_pkg::cmd_t      cmd,
  output nps_pkg::status_t   status,
  input  logic [1:0]         in_kind,
  input  nps_pkg::coord_t    in_px,
  input  nps_pkg::coord_t    in_py,
  input  nps_pkg::coord_t    in_pz,
  output logic               found,
  output nps_pkg::index_t    best_index,
  output nps_pkg::coord_t    best_x,
  output nps_pkg::coord_t    best_y,
  output nps_pkg::coord_t    best_z,
  output logic               table_full
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  nps_pkg::point_t mem [MAX_POINTS];

  logic [CW-1:0]   count;
  logic            full;
  nps_pkg::kind_t  kind_q;
  nps_pkg::point_t query;
  logic [CW-1:0]   ins_index;
  logic            ins_full;

  // Scan pipeline: memory read, squares, sum, compare.
  logic [IW-1:0]   rd_addr;
  logic            v0;
  logic            v1;
  logic            v2;
  nps_pkg::point_t pt0;
  nps_pkg::point_t pt1;
  nps_pkg::point_t pt2;
  logic [IW-1:0]   idx0;
  logic [IW-1:0]   idx1;
  logic [IW-1:0]   idx2;
  nps_pkg::sq_t    sq_x;
  nps_pkg::sq_t    sq_y;
  nps_pkg::sq_t    sq_z;
  nps_pkg::dist_t  dist2;

  logic            have;
  nps_pkg::dist_t  best_d;
  nps_pkg::point_t best_pt;
  logic [IW-1:0]   best_idx;

  logic [nps_pkg::CoordBits-1:0] mag_x;
  logic [nps_pkg::CoordBits-1:0] mag_y;
  logic [nps_pkg::CoordBits-1:0] mag_z;

  assign full = (count == CW'(MAX_POINTS));
  assign status.empty = (count == '0);
  assign status.scan_last = ((CW'(rd_addr) + CW'(1)) == count);
  assign status.pipe_busy = v0 || v1 || v2;

  assign mag_x = nps_pkg::abs_diff(query.x, pt0.x);
  assign mag_y = nps_pkg::abs_diff(query.y, pt0.y);
  assign mag_z = nps_pkg::abs_diff(query.z, pt0.z);

  always_ff @(posedge clk) begin
    if (cmd.accept && nps_pkg::kind_t'(in_kind) == nps_pkg::KIND_INSERT && !full) begin
      mem[count[IW-1:0]] <= '{x: in_px, y: in_py, z: in_pz};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      pt0 <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      have <= 1'b0;
      rd_addr <= '0;
    end else begin
      v0 <= cmd.rd;
      v1 <= v0;
      v2 <= v1;
      if (cmd.rd) begin
        rd_addr <= rd_addr + IW'(1);
      end
      if (cmd.accept) begin
        rd_addr <= '0;
        have <= 1'b0;
        case (nps_pkg::kind_t'(in_kind))
          nps_pkg::KIND_CLEAR: begin
            count <= '0;
          end
          nps_pkg::KIND_INSERT: begin
            if (!full) begin
              count <= count + CW'(1);
            end
          end
          default: begin
          end
        endcase
      end else if (v2 && (!have || dist2 < best_d)) begin
        have <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= nps_pkg::kind_t'(in_kind);
      query <= '{x: in_px, y: in_py, z: in_pz};
      ins_index <= count;
      ins_full <= full;
    end
    if (cmd.rd) begin
      idx0 <= rd_addr;
    end
    if (v0) begin
      sq_x <= mag_x * mag_x;
      sq_y <= mag_y * mag_y;
      sq_z <= mag_z * mag_z;
      pt1 <= pt0;
      idx1 <= idx0;
    end
    if (v1) begin
      dist2 <= nps_pkg::DistBits'(sq_x) + nps_pkg::DistBits'(sq_y)
             + nps_pkg::DistBits'(sq_z);
      pt2 <= pt1;
      idx2 <= idx1;
    end
    // Strict less-than keeps the earliest point among equal distances.
    if (v2 && (!have || dist2 < best_d)) begin
      best_d <= dist2;
      best_pt <= pt2;
      best_idx <= idx2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found <= 1'b0;
      best_index <= '0;
      best_x <= '0;
      best_y <= '0;
      best_z <= '0;
      table_full <= 1'b0;
      case (kind_q)
        nps_pkg::KIND_INSERT: begin
          table_full <= ins_full;
          if (!ins_full) begin
            best_index <= nps_pkg::IndexBits'(ins_index);
          end
        end
        nps_pkg::KIND_QUERY: begin
          if (have) begin
            found <= 1'b1;
            best_index <= nps_pkg::IndexBits'(best_idx);
            best_x <= best_pt.x;
            best_y <= best_pt.y;
            best_z <= best_pt.z;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/nearest_point_search_3d.sv =====
// Top level of the nearest point search block: controller plus datapath.
// Depends on nps_pkg, nps_in_if, nps_out_if, nps_ctrl and nps_datapath.
//
//   channel  modport  word
//   item     sink     kind, px, py, pz
//   result   source   found, best_index, best_x, best_y, best_z, table_full
//
// Clear, insert, undefined and empty-table query words go from accept to the
// result state, which loads the result register once it is free; then the next
// word can be accepted. A query scans first: the single read port of the point
// memory delivers one point per cycle into a three-stage distance pipeline,
// and the result loads once it drains. One word is in work at a time; the result
// register lets the next word be accepted while the last result waits. Reset
// empties the table at once through the fill count, with no clearing pass.
module nearest_point_search_3d #(
  parameter int MAX_POINTS = nps_pkg::MaxPointsDefault
) (
  input logic       clk,
  input logic       rst,
  nps_in_if.sink    item,
  nps_out_if.source result
);

  nps_pkg::cmd_t    cmd;
  nps_pkg::status_t status;

  nps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_kind   (item.kind),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  nps_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_kind    (item.kind),
    .in_px      (item.px),
    .in_py      (item.py),
    .in_pz      (item.pz),
    .found      (result.found),
    .best_index (result.best_index),
    .best_x     (result.best_x),
    .best_y     (result.best_y),
    .best_z     (result.best_z),
    .table_full (result.table_full)
  );

endmodule

// ===== bench/tb_top.sv =====
// Testbench for nearest_point_search_3d: directed and random clear, insert, query and
// undefined words, checked against a point table kept in the bench. Depends on nps_pkg,
// nps_in_if, nps_out_if and the RTL of the block.
package nps_tb_pkg;
  import nps_pkg::*;

  localparam int MaxEntries = 1024;
  localparam logic [1:0] KindUndefined = 2'd3;

  typedef struct packed {
    logic   found;
    index_t best_index;
    coord_t best_x;
    coord_t best_y;
    coord_t best_z;
    logic   table_full;
  } search_result_t;

  function automatic longint squared_distance(point_t a, point_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  class nearest_point_table;
    point_t         points[MaxEntries];
    int unsigned    count;
    search_result_t pending[$];
    int unsigned    mismatches, checked, peak;
    int unsigned    n_clear, n_insert, n_dropped, n_query, n_empty_query, n_undefined;

    // Applies one accepted word to the table and queues the result it must produce.
    function void note_item(logic [1:0] kind, coord_t x, coord_t y, coord_t z);
      search_result_t r;
      point_t         probe;
      longint         best_d, d;
      r = '0;
      probe = {x, y, z};
      case (kind)
        KIND_CLEAR: begin
          count = 0;
          n_clear++;
        end
        KIND_INSERT: begin
          n_insert++;
          if (count >= MaxEntries) begin
            r.table_full = 1'b1;
            n_dropped++;
          end else begin
            points[count] = probe;
            r.best_index = index_t'(count);
            count++;
            if (count > peak) peak = count;
          end
        end
        KIND_QUERY: begin
          n_query++;
          if (count == 0) n_empty_query++;
          best_d = 0;
          // Strict less-than keeps the earliest of equally near points.
          for (int unsigned i = 0; i < count; i++) begin
            d = squared_distance(probe, points[i]);
            if (i == 0 || d < best_d) begin
              best_d = d;
              r.best_index = index_t'(i);
              r.best_x = points[i].x;
              r.best_y = points[i].y;
              r.best_z = points[i].z;
            end
          end
          r.found = (count != 0);
        end
        default: n_undefined++;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(search_result_t got);
      search_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result word %0d arrived with nothing expected", checked);
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found || got.best_index !== want.best_index ||
          got.best_x !== want.best_x || got.best_y !== want.best_y ||
          got.best_z !== want.best_z || got.table_full !== want.table_full) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result word %0d differs:", checked);
          $display("  expected found=%0d index=%0d x=%0d y=%0d z=%0d full=%0d",
                   want.found, want.best_index, want.best_x, want.best_y, want.best_z,
                   want.table_full);
          $display("  actual   found=%0d index=%0d x=%0d y=%0d z=%0d full=%0d",
                   got.found, got.best_index, got.best_x, got.best_y, got.best_z,
                   got.table_full);
        end
      end
    endfunction
  endclass
endpackage

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nps_pkg::*;
  import nps_tb_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int RandomItems = 580;
  localparam coord_t CMin = 16'sh8000;
  localparam coord_t CMax = 16'sh7FFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned words_sent = 0;
  longint unsigned cycles = 0;
  nearest_point_table point_table = new();

  nps_in_if  item ();
  nps_out_if result ();

  nearest_point_search_3d DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    result.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("run stopped after %0d cycles with %0d results outstanding", cycles,
               point_table.pending.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      point_table.check_result({result.found, result.best_index, result.best_x,
                                result.best_y, result.best_z, result.table_full});
  end

  // Drives one word, with random idle cycles ahead of it, and notes it once accepted.
  task automatic send_word(input logic [1:0] kind, input coord_t x, input coord_t y,
                           input coord_t z);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      item.valid <= 1'b0;
      @(negedge clk);
    end
    item.valid <= 1'b1;
    item.kind  <= kind;
    item.px    <= x;
    item.py    <= y;
    item.pz    <= z;
    do @(posedge clk); while (!item.ready);
    point_table.note_item(kind, x, y, z);
    if (kind != KindUndefined) words_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    item.valid <= 1'b0;
    while (point_table.pending.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t random_coord();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? CMax : CMin;
      1, 2: return coord_t'($urandom);
      default: return coord_t'($urandom_range(4095) - 2048);
    endcase
  endfunction

  function automatic point_t random_point();
    return {random_coord(), random_coord(), random_coord()};
  endfunction

  function automatic coord_t nudge(coord_t c, int span);
    int v;
    v = int'(c) + int'($urandom_range(2 * span)) - span;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  // Queries mostly land on or near stored points so that the search has close rivals.
  function automatic point_t query_point();
    point_t      p;
    int unsigned pick;
    if (point_table.count == 0) return random_point();
    pick = $urandom_range(99);
    p = point_table.points[$urandom_range(point_table.count - 1)];
    if (pick < 40) begin
      p.x = nudge(p.x, 40);
      p.y = nudge(p.y, 40);
      p.z = nudge(p.z, 40);
    end else if (pick >= 90) begin
      p.x = $urandom_range(1) ? CMax : CMin;
      p.y = $urandom_range(1) ? CMax : CMin;
      p.z = $urandom_range(1) ? CMax : CMin;
    end else if (pick >= 60) begin
      p = random_point();
    end
    return p;
  endfunction

  task automatic run_directed();
    send_word(KIND_QUERY, 0, 0, 0);
    send_word(KindUndefined, -1, -1, -1);
    send_word(KIND_INSERT, CMin, CMin, CMin);
    send_word(KIND_INSERT, CMax, CMax, CMax);
    send_word(KIND_INSERT, 0, 0, 0);
    send_word(KIND_INSERT, coord_t'(16'h5555), coord_t'(16'hAAAA), coord_t'(16'h5555));
    send_word(KIND_QUERY, CMax, CMax, CMax);
    send_word(KIND_QUERY, CMin, CMin, CMin + 1);
    send_word(KIND_QUERY, CMax, CMin, CMax);
    send_word(KIND_INSERT, 0, 0, 0);
    // Two stored copies of the origin: the earlier one must win.
    send_word(KIND_QUERY, 3, -2, 1);
    send_word(KindUndefined, CMax, CMax, CMax);
    send_word(KIND_QUERY, coord_t'(16'hAAAA), coord_t'(16'h5555), coord_t'(16'hAAAA));
    send_word(KIND_CLEAR, CMax, CMin, CMax);
    send_word(KIND_QUERY, 0, 0, 0);
    send_word(KIND_INSERT, 1000, -2000, 300);
    send_word(KIND_INSERT, -1000, -2000, 300);
    send_word(KIND_QUERY, 0, -2000, 300);
    send_word(KIND_INSERT, 0, -2000, 300);
    send_word(KIND_QUERY, 0, -1999, 300);
    wait_drained();
  endtask

  // Fills the table to the last slot, then tries inserts that must be dropped.
  task automatic run_full_table();
    point_t p;
    send_word(KIND_CLEAR, 0, 0, 0);
    for (int i = 0; i < MaxEntries; i++) begin
      p = random_point();
      send_word(KIND_INSERT, p.x, p.y, p.z);
    end
    for (int i = 0; i < 3; i++) begin
      p = random_point();
      send_word(KIND_INSERT, p.x, p.y, p.z);
    end
    p = point_table.points[MaxEntries - 1];
    send_word(KIND_QUERY, p.x, p.y, p.z);
    p = random_point();
    send_word(KIND_QUERY, p.x, p.y, p.z);
    send_word(KindUndefined, p.y, p.z, p.x);
    send_word(KIND_INSERT, p.z, p.x, p.y);
    send_word(KIND_CLEAR, p.x, p.y, p.z);
    send_word(KIND_INSERT, p.x, p.y, p.z);
    send_word(KIND_QUERY, 0, 0, 0);
    wait_drained();
  endtask

  task automatic run_search_sequence();
    int unsigned n;
    point_t      p;
    if (point_table.count > 200 || $urandom_range(99) < 85)
      send_word(KIND_CLEAR, random_coord(), random_coord(), random_coord());
    n = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(16, 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (point_table.count != 0 && $urandom_range(7) == 0)
        p = point_table.points[$urandom_range(point_table.count - 1)];
      else
        p = random_point();
      send_word(KIND_INSERT, p.x, p.y, p.z);
    end
    n = $urandom_range(8, 1);
    for (int unsigned i = 0; i < n; i++) begin
      p = query_point();
      send_word(KIND_QUERY, p.x, p.y, p.z);
    end
  endtask

  task automatic run_random_phase(input int unsigned sender_idle, input int unsigned stall);
    int unsigned start, pick;
    point_t      p;
    idle_pct  = sender_idle;
    stall_pct = stall;
    start = words_sent;
    while (words_sent - start < RandomItems / 4) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        run_search_sequence();
      end else if (pick < 90) begin
        p = random_point();
        send_word(2'($urandom_range(3)), p.x, p.y, p.z);
      end else begin
        // Inserts with neither a clear ahead nor a query after.
        repeat ($urandom_range(6, 1)) begin
          p = random_point();
          send_word(KIND_INSERT, p.x, p.y, p.z);
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    item.valid   = 1'b0;
    item.kind    = KIND_CLEAR;
    item.px      = '0;
    item.py      = '0;
    item.pz      = '0;
    result.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    run_full_table();
    run_random_phase(0, 0);
    run_random_phase(47, 0);
    run_random_phase(0, 47);
    run_random_phase(27, 27);
    repeat (20) @(posedge clk);

    $display("covered %0d clears, %0d inserts (%0d dropped on a full table), %0d queries",
             point_table.n_clear, point_table.n_insert, point_table.n_dropped,
             point_table.n_query);
    $display("with %0d on an empty table, %0d undefined words, tables up to %0d points, %0d checked",
             point_table.n_empty_query, point_table.n_undefined, point_table.peak,
             point_table.checked);
    if (point_table.mismatches == 0 && point_table.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
